FILE: src/ipv4hc_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hc_pkg
// Shared constants, status codes and types of the IPv4 header checker.
// ----------------------------------------------------------------------------
package ipv4hc_pkg;

  // Default width of the packet length counter.
  localparam int LENGTH_BITS_DEFAULT = 16;

  // Verdict codes, in the order of their numeric values.
  typedef logic [2:0] status_t;
  localparam status_t STATUS_OK        = 3'd0;
  localparam status_t STATUS_VERSION   = 3'd1;
  localparam status_t STATUS_HDR_LEN   = 3'd2;
  localparam status_t STATUS_TTL       = 3'd3;
  localparam status_t STATUS_CHECKSUM  = 3'd4;
  localparam status_t STATUS_DEST      = 3'd5;
  localparam status_t STATUS_TRUNCATED = 3'd6;

  // Header layout and protocol constants.
  localparam logic [3:0]  IP_VERSION       = 4'd4;
  localparam logic [5:0]  MIN_HDR_BYTES    = 6'd20;
  localparam int          TTL_POS          = 8;
  localparam int          DEST_FIRST_POS   = 16;
  localparam int          DEST_LAST_POS    = 19;
  localparam logic [15:0] CHECKSUM_GOOD    = 16'hFFFF;
  localparam logic [31:0] BROADCAST_ADDR   = 32'hFFFF_FFFF;

  // One result item.
  typedef struct packed {
    status_t     status;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;
  } verdict_t;

endpackage

FILE: src/ipv4hc_ifs.sv
// ----------------------------------------------------------------------------
// ipv4hc channel interfaces
// Valid/ready channels for packet bytes in and verdict items out.
// ----------------------------------------------------------------------------
interface ipv4hc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipv4hc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  header_bytes;
  logic [15:0] payload_bytes;

  modport source (output valid, output status, output header_bytes, output payload_bytes,
                  input ready);
  modport sink   (input valid, input status, input header_bytes, input payload_bytes,
                  output ready);
endinterface

FILE: src/ipv4_header_checker.sv
// ----------------------------------------------------------------------------
// ipv4_header_checker
// The verdict item is registered and appears in the cycle after the final byte is taken.
// Throughput: one byte per cycle unless stalled; each byte updates the header state once.
// A pending verdict stalls input only while the output side holds it off.
// Reset (rst, synchronous) clears local_address, all packet state and out_valid.
// ----------------------------------------------------------------------------
module ipv4_header_checker #(
  parameter int LENGTH_BITS = ipv4hc_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  ipv4hc_in_if.sink           pkt_in,
  ipv4hc_out_if.source        verdict_out
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Configuration.
  logic [31:0] local_address;

  // Per-packet state. These registers are the working state of the packet
  // currently streaming in; they return to zero after every final byte.
  logic [LENGTH_BITS-1:0] byte_position;
  logic [3:0]             version_field;
  logic [3:0]             header_words;
  logic [7:0]             time_to_live;
  logic [20:0]            running_sum;
  logic [7:0]             held_high_byte;
  logic [31:0]            destination_address;

  // Output register.
  logic                   out_valid;
  ipv4hc_pkg::verdict_t   out_verdict;

  // Next-state values for the byte being accepted.
  logic [LENGTH_BITS-1:0] byte_position_next;
  logic [3:0]             version_field_next;
  logic [3:0]             header_words_next;
  logic [7:0]             time_to_live_next;
  logic [20:0]            running_sum_next;
  logic [7:0]             held_high_byte_next;
  logic [31:0]            destination_address_next;
  logic [5:0]             hdr_len;
  logic                   in_header;
  logic                   accept;
  ipv4hc_pkg::verdict_t   verdict;

  // The output register frees up in the same cycle its item is taken, so a
  // new byte can be accepted every cycle while the consumer keeps up.
  assign pkt_in.ready = !out_valid || verdict_out.ready;
  assign accept       = pkt_in.valid && pkt_in.ready;

  // Byte 0 carries version and IHL; the header length used for this same
  // byte already reflects the IHL if this is byte 0.
  always_comb begin
    version_field_next       = version_field;
    header_words_next        = header_words;
    time_to_live_next        = time_to_live;
    destination_address_next = destination_address;
    if (byte_position == '0) begin
      version_field_next = pkt_in.data_byte[7:4];
      header_words_next  = pkt_in.data_byte[3:0];
    end
    if (byte_position == LENGTH_BITS'(ipv4hc_pkg::TTL_POS)) begin
      time_to_live_next = pkt_in.data_byte;
    end
    // The destination address shifts in over bytes 16 through 19.
    if (byte_position >= LENGTH_BITS'(ipv4hc_pkg::DEST_FIRST_POS) &&
        byte_position <= LENGTH_BITS'(ipv4hc_pkg::DEST_LAST_POS)) begin
      destination_address_next = {destination_address[23:0], pkt_in.data_byte};
    end
  end

  assign hdr_len   = {header_words_next, 2'b00};
  assign in_header = byte_position < LENGTH_BITS'(hdr_len);

  // Header words are big endian: even positions hold the high byte, odd
  // positions complete the word and add it into the running sum.
  always_comb begin
    held_high_byte_next = held_high_byte;
    running_sum_next    = running_sum;
    if (in_header) begin
      if (!byte_position[0]) begin
        held_high_byte_next = pkt_in.data_byte;
      end else begin
        running_sum_next = running_sum + 21'({held_high_byte, pkt_in.data_byte});
      end
    end
  end

  // The byte count saturates rather than wrapping on very long packets.
  assign byte_position_next = (byte_position != LEN_MAX) ?
                              byte_position + LENGTH_BITS'(1) : LEN_MAX;

  ipv4hc_verdict #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_verdict (
    .version_field       (version_field_next),
    .header_bytes        (hdr_len),
    .total_bytes         (byte_position_next),
    .time_to_live        (time_to_live_next),
    .running_sum         (running_sum_next),
    .destination_address (destination_address_next),
    .local_address       (local_address),
    .verdict             (verdict)
  );

  // Control and packet state.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address       <= '0;
      byte_position       <= '0;
      version_field       <= '0;
      header_words        <= '0;
      time_to_live        <= '0;
      running_sum         <= '0;
      held_high_byte      <= '0;
      destination_address <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        local_address <= cfg_wdata;
      end
      if (accept && pkt_in.last_byte) begin
        // Final byte: the verdict is registered and the next packet starts
        // from a clean slate.
        byte_position       <= '0;
        version_field       <= '0;
        header_words        <= '0;
        time_to_live        <= '0;
        running_sum         <= '0;
        held_high_byte      <= '0;
        destination_address <= '0;
        out_valid           <= 1'b1;
      end else begin
        if (accept) begin
          byte_position       <= byte_position_next;
          version_field       <= version_field_next;
          header_words        <= header_words_next;
          time_to_live        <= time_to_live_next;
          running_sum         <= running_sum_next;
          held_high_byte      <= held_high_byte_next;
          destination_address <= destination_address_next;
        end
        if (verdict_out.ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Verdict payload is loaded only with a final byte.
  always_ff @(posedge clk) begin
    if (accept && pkt_in.last_byte) begin
      out_verdict <= verdict;
    end
  end

  assign verdict_out.valid         = out_valid;
  assign verdict_out.status        = out_verdict.status;
  assign verdict_out.header_bytes  = out_verdict.header_bytes;
  assign verdict_out.payload_bytes = out_verdict.payload_bytes;

`ifndef SYNTH
  // A final byte always leaves the packet state cleared.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && pkt_in.last_byte |=> byte_position == '0 && running_sum == '0)
    else $error("packet state not cleared after final byte");

  // A verdict only appears after a final byte was taken.
  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept && pkt_in.last_byte))
    else $error("verdict without a final byte");

  // An accepted header is at least the minimum length.
  a_ok_header_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_verdict.status == ipv4hc_pkg::STATUS_OK |->
      out_verdict.header_bytes >= ipv4hc_pkg::MIN_HDR_BYTES)
    else $error("ok verdict with short header");

  // Rejected packets deliver no payload.
  a_reject_no_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_verdict.status != ipv4hc_pkg::STATUS_OK |->
      out_verdict.payload_bytes == '0)
    else $error("payload length on a rejected packet");
`endif

endmodule

FILE: src/ipv4hc_verdict.sv
// ----------------------------------------------------------------------------
// ipv4hc_verdict
// Folds the header sum and ranks the header checks into one verdict.
// ----------------------------------------------------------------------------
module ipv4hc_verdict #(
  parameter int LENGTH_BITS = ipv4hc_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic [3:0]             version_field,
  input  logic [5:0]             header_bytes,
  input  logic [LENGTH_BITS-1:0] total_bytes,
  input  logic [7:0]             time_to_live,
  input  logic [20:0]            running_sum,
  input  logic [31:0]            destination_address,
  input  logic [31:0]            local_address,
  output ipv4hc_pkg::verdict_t   verdict
);

  logic [16:0]            fold1;
  logic [16:0]            fold2;
  logic                   sum_good;
  logic                   dest_good;
  logic [LENGTH_BITS-1:0] hdr_wide;
  logic [LENGTH_BITS-1:0] payload_wide;

  // Two end-around folds bring the 21-bit sum into 16 bits.
  assign fold1     = 17'(running_sum[20:16]) + 17'(running_sum[15:0]);
  assign fold2     = 17'(fold1[16]) + 17'(fold1[15:0]);
  assign sum_good  = (fold2 == 17'(ipv4hc_pkg::CHECKSUM_GOOD));
  assign dest_good = (destination_address == ipv4hc_pkg::BROADCAST_ADDR) ||
                     (destination_address == local_address);

  assign hdr_wide     = LENGTH_BITS'(header_bytes);
  assign payload_wide = total_bytes - hdr_wide;

  always_comb begin
    verdict.header_bytes  = header_bytes;
    verdict.payload_bytes = '0;
    if (version_field != ipv4hc_pkg::IP_VERSION) begin
      verdict.status = ipv4hc_pkg::STATUS_VERSION;
    end else if (header_bytes < ipv4hc_pkg::MIN_HDR_BYTES) begin
      verdict.status = ipv4hc_pkg::STATUS_HDR_LEN;
    end else if (total_bytes < hdr_wide) begin
      verdict.status = ipv4hc_pkg::STATUS_TRUNCATED;
    end else if (time_to_live == 8'd0) begin
      verdict.status = ipv4hc_pkg::STATUS_TTL;
    end else if (!sum_good) begin
      verdict.status = ipv4hc_pkg::STATUS_CHECKSUM;
    end else if (!dest_good) begin
      verdict.status = ipv4hc_pkg::STATUS_DEST;
    end else begin
      verdict.status        = ipv4hc_pkg::STATUS_OK;
      verdict.payload_bytes = 16'(payload_wide);
    end
  end

endmodule
